// ===== hw/rtl/mtw_pkg.sv =====
// Shared types and constants for the multi-thread heartbeat watchdog.
// Holds command, status and register codes, the controller state type and the result word.
// No dependencies; mtw_ctrl and the core in hw/rtl refer to it by scoped names.
package mtw_pkg;

  localparam int ID_W     = 32;
  localparam int TICK_W   = 32;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 3;
  localparam int CFG_W    = 32;

  localparam logic [CMD_W-1:0] CMD_BEAT    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SUSPEND = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RESUME  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CHECK   = 3'd4;

  localparam logic [STATUS_W-1:0] STAT_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL        = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND   = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_RESUME_ZERO = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_SUSPEND_SAT = 3'd4;

  localparam logic REG_HANG_TIMEOUT = 1'b0;
  localparam logic REG_CHECK_ENABLE = 1'b1;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_SCAN,
    CS_UPDATE,
    CS_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic                hung_found;
    logic [ID_W-1:0]     hung_id;
    logic                beating;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage

// ===== hw/rtl/mtw_slot_mem.sv =====
// Slot table memory: one entry per slot holding client id, last beat tick and suspend count.
// Synchronous write, synchronous read: rd_data is registered and updated in the cycle after rd_en.
// Depends on nothing beyond its parameters.
module mtw_slot_mem #(
  parameter int DEPTH  = 16,
  parameter int WIDTH  = 72,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/mtw_ctrl.sv =====
// Command sequencer: scans the slot memory one entry a cycle, then writes back at most one entry.
// Keeps the slot valid bits in flip-flops and produces one result word per command.
// Depends on mtw_pkg and mtw_slot_mem.
module mtw_ctrl #(
  parameter int NUM_SLOTS    = 16,
  parameter int SUSPEND_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [mtw_pkg::CMD_W-1:0]    cmd,
  input  logic [mtw_pkg::ID_W-1:0]     client_id,
  input  logic [mtw_pkg::TICK_W-1:0]   now_ticks,
  input  logic [mtw_pkg::TICK_W-1:0]   hang_timeout,
  input  logic                         check_enable,
  output logic                         res_valid,
  input  logic                         res_take,
  output mtw_pkg::result_t             res
);

  localparam int IDX_W   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W   = $clog2(NUM_SLOTS + 1);
  localparam int ENTRY_W = mtw_pkg::ID_W + mtw_pkg::TICK_W + SUSPEND_BITS;
  localparam logic [IDX_W-1:0]        LAST_IDX = IDX_W'(NUM_SLOTS - 1);
  localparam logic [CNT_W-1:0]        SLOTS_C  = CNT_W'(NUM_SLOTS);
  localparam logic [SUSPEND_BITS-1:0] SUSP_MAX = {SUSPEND_BITS{1'b1}};
  localparam logic [SUSPEND_BITS-1:0] SUSP_ZERO = '0;

  mtw_pkg::ctrl_state_t state, state_next;

  logic [mtw_pkg::CMD_W-1:0]  cmd_q;
  logic [mtw_pkg::ID_W-1:0]   id_q;
  logic [mtw_pkg::TICK_W-1:0] now_q;
  logic [CNT_W-1:0]           cnt;
  logic                       rd_en;
  logic                       rd_vld;
  logic [IDX_W-1:0]           rd_idx;
  logic [ENTRY_W-1:0]         rd_data;
  logic [NUM_SLOTS-1:0]       valid;

  // Scan results: lowest matching slot, lowest free slot, lowest hung slot.
  logic                       hit;
  logic [IDX_W-1:0]           hit_idx;
  logic [SUSPEND_BITS-1:0]    hit_cnt;
  logic [mtw_pkg::TICK_W-1:0] hit_last;
  logic                       free_ok;
  logic [IDX_W-1:0]           free_idx;
  logic                       hung_ok;
  logic [IDX_W-1:0]           hung_idx;
  logic [mtw_pkg::ID_W-1:0]   hung_id;

  logic [mtw_pkg::ID_W-1:0]   e_id;
  logic [mtw_pkg::TICK_W-1:0] e_last;
  logic [SUSPEND_BITS-1:0]    e_cnt;
  logic [mtw_pkg::TICK_W-1:0] age;
  logic                       armed;
  logic                       e_valid;
  logic                       e_match;
  logic                       e_hung;

  logic                       wr_en;
  logic [IDX_W-1:0]           wr_addr;
  logic [ENTRY_W-1:0]         wr_data;
  logic                       vset;
  logic                       vclr;
  logic [IDX_W-1:0]           vidx;
  logic [SUSPEND_BITS-1:0]    dec_cnt;
  mtw_pkg::result_t           res_next;

  mtw_slot_mem #(
    .DEPTH  (NUM_SLOTS),
    .WIDTH  (ENTRY_W),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (cnt[IDX_W-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign {e_id, e_last, e_cnt} = rd_data;
  assign armed   = check_enable && (hang_timeout != '0);
  assign age     = now_q - e_last;
  assign e_valid = rd_vld && valid[rd_idx];
  assign e_match = e_valid && (e_id == id_q);
  assign e_hung  = e_valid && armed && (e_cnt == SUSP_ZERO) && (age > hang_timeout);
  assign dec_cnt = hit_cnt - SUSPEND_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mtw_pkg::CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    rd_en      = 1'b0;
    res_valid  = 1'b0;
    unique case (state)
      mtw_pkg::CS_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = mtw_pkg::CS_SCAN;
        end
      end
      mtw_pkg::CS_SCAN: begin
        rd_en = (cnt < SLOTS_C);
        if (rd_vld && (rd_idx == LAST_IDX)) begin
          state_next = mtw_pkg::CS_UPDATE;
        end
      end
      mtw_pkg::CS_UPDATE: begin
        state_next = mtw_pkg::CS_DONE;
      end
      mtw_pkg::CS_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_next = mtw_pkg::CS_IDLE;
        end
      end
      default: begin
        state_next = mtw_pkg::CS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      valid  <= '0;
    end else begin
      rd_vld <= rd_en;
      if (vset) begin
        valid[vidx] <= 1'b1;
      end
      if (vclr) begin
        valid[vidx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= cnt[IDX_W-1:0];
    if (state == mtw_pkg::CS_IDLE && in_valid) begin
      cmd_q   <= cmd;
      id_q    <= client_id;
      now_q   <= now_ticks;
      cnt     <= '0;
      hit     <= 1'b0;
      free_ok <= 1'b0;
      hung_ok <= 1'b0;
    end else if (state == mtw_pkg::CS_SCAN) begin
      if (rd_en) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (e_match && !hit) begin
        hit      <= 1'b1;
        hit_idx  <= rd_idx;
        hit_cnt  <= e_cnt;
        hit_last <= e_last;
      end
      if (rd_vld && !valid[rd_idx] && !free_ok) begin
        free_ok  <= 1'b1;
        free_idx <= rd_idx;
      end
      if (e_hung && !hung_ok) begin
        hung_ok  <= 1'b1;
        hung_idx <= rd_idx;
        hung_id  <= e_id;
      end
    end
    if (state == mtw_pkg::CS_UPDATE) begin
      res <= res_next;
    end
  end

  // Write-back decision. Ids are unique among valid slots, so a removed id stops beating.
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = hit_idx;
    wr_data  = {id_q, now_q, hit_cnt};
    vset     = 1'b0;
    vclr     = 1'b0;
    vidx     = hit_idx;
    res_next.hung_found = 1'b0;
    res_next.hung_id    = '0;
    res_next.beating    = hit && (hit_cnt == SUSP_ZERO);
    res_next.status     = mtw_pkg::STAT_OK;
    if (state == mtw_pkg::CS_UPDATE) begin
      unique case (cmd_q)
        mtw_pkg::CMD_BEAT: begin
          if (hit) begin
            wr_en = 1'b1;
          end else if (free_ok) begin
            wr_en   = 1'b1;
            wr_addr = free_idx;
            wr_data = {id_q, now_q, SUSP_ZERO};
            vset    = 1'b1;
            vidx    = free_idx;
            res_next.beating = 1'b1;
          end else begin
            res_next.status = mtw_pkg::STAT_FULL;
          end
        end
        mtw_pkg::CMD_REMOVE: begin
          if (hit) begin
            vclr = 1'b1;
            res_next.beating = 1'b0;
          end else begin
            res_next.status = mtw_pkg::STAT_NOT_FOUND;
          end
        end
        mtw_pkg::CMD_SUSPEND: begin
          if (!hit) begin
            res_next.status = mtw_pkg::STAT_NOT_FOUND;
          end else if (hit_cnt == SUSP_MAX) begin
            res_next.status = mtw_pkg::STAT_SUSPEND_SAT;
          end else begin
            wr_en   = 1'b1;
            wr_data = {id_q, hit_last, hit_cnt + SUSPEND_BITS'(1)};
            res_next.beating = 1'b0;
          end
        end
        mtw_pkg::CMD_RESUME: begin
          if (!hit) begin
            res_next.status = mtw_pkg::STAT_NOT_FOUND;
          end else if (hit_cnt == SUSP_ZERO) begin
            res_next.status = mtw_pkg::STAT_RESUME_ZERO;
          end else begin
            wr_en = 1'b1;
            // Leaving the last suspend restamps the entry.
            wr_data = {id_q, (dec_cnt == SUSP_ZERO) ? now_q : hit_last, dec_cnt};
            res_next.beating = (dec_cnt == SUSP_ZERO);
          end
        end
        mtw_pkg::CMD_CHECK: begin
          if (hung_ok) begin
            wr_en   = 1'b1;
            wr_addr = hung_idx;
            wr_data = {hung_id, now_q, SUSP_ZERO};
            res_next.hung_found = 1'b1;
            res_next.hung_id    = hung_id;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/multi_thread_heartbeat_watchdog_core.sv =====
// Top level of the multi-thread heartbeat watchdog: configuration registers and result register.
// Depends on mtw_pkg and mtw_ctrl (which holds mtw_slot_mem).
//
//   channel  | signals                                         | direction
//   ---------+-------------------------------------------------+----------
//   input    | in_valid, in_stall, cmd, client_id, now_ticks   | in
//   result   | out_valid, out_stall, hung_found, hung_id,      | out
//            | beating, status                                 |
//   config   | cfg_we, cfg_index, cfg_data                     | in
//
// Every command walks the whole slot memory through its single read port, one entry a cycle,
// then writes back at most one entry in CS_UPDATE before the result is offered in CS_DONE.
// A new word is taken once the previous result has moved into the output register.
// Reset clears the valid bits, the configuration registers and the handshake state; no memory sweep is needed.
// A stalled result holds in the output register while the next command is already scanning.
module multi_thread_heartbeat_watchdog_core #(
  parameter int NUM_SLOTS    = 16,
  parameter int SUSPEND_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mtw_pkg::CMD_W-1:0]     cmd,
  input  logic [mtw_pkg::ID_W-1:0]      client_id,
  input  logic [mtw_pkg::TICK_W-1:0]    now_ticks,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          hung_found,
  output logic [mtw_pkg::ID_W-1:0]      hung_id,
  output logic                          beating,
  output logic [mtw_pkg::STATUS_W-1:0]  status,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [mtw_pkg::CFG_W-1:0]     cfg_data
);

  logic [mtw_pkg::TICK_W-1:0] hang_timeout;
  logic                       check_enable;
  logic                       res_valid;
  logic                       res_take;
  mtw_pkg::result_t           res;

  always_ff @(posedge clk) begin
    if (rst) begin
      hang_timeout <= '0;
      check_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mtw_pkg::REG_HANG_TIMEOUT: hang_timeout <= cfg_data[mtw_pkg::TICK_W-1:0];
        mtw_pkg::REG_CHECK_ENABLE: check_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  mtw_ctrl #(
    .NUM_SLOTS    (NUM_SLOTS),
    .SUSPEND_BITS (SUSPEND_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .client_id    (client_id),
    .now_ticks    (now_ticks),
    .hang_timeout (hang_timeout),
    .check_enable (check_enable),
    .res_valid    (res_valid),
    .res_take     (res_take),
    .res          (res)
  );

  assign res_take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      hung_found <= res.hung_found;
      hung_id    <= res.hung_id;
      beating    <= res.beating;
      status     <= res.status;
    end
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for multi_thread_heartbeat_watchdog_core.
// It keeps its own watchdog table and predicts each result word from the commands it sends.
// Depends on mtw_pkg and the core RTL only.
module tb;
  import mtw_pkg::*;

  localparam int SLOTS     = 16;
  localparam int NEST_BITS = 8;
  localparam int POOL      = 24;
  localparam int SETTLE    = 40;
  localparam int PHASES    = 5;

  typedef struct {
    logic [CMD_W-1:0]  op;
    logic [ID_W-1:0]   id;
    logic [TICK_W-1:0] ticks;
  } command_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [CMD_W-1:0]    cmd = '0;
  logic [ID_W-1:0]     client_id = '0;
  logic [TICK_W-1:0]   now_ticks = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                hung_found;
  logic [ID_W-1:0]     hung_id;
  logic                beating;
  logic [STATUS_W-1:0] status;
  logic                cfg_we = 1'b0;
  logic                cfg_index = REG_HANG_TIMEOUT;
  logic [CFG_W-1:0]    cfg_data = '0;

  multi_thread_heartbeat_watchdog_core #(
    .NUM_SLOTS    (SLOTS),
    .SUSPEND_BITS (NEST_BITS)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .client_id  (client_id),
    .now_ticks  (now_ticks),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hung_found (hung_found),
    .hung_id    (hung_id),
    .beating    (beating),
    .status     (status),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Predicted watchdog table and register copies.
  bit                  slot_used   [SLOTS];
  bit [ID_W-1:0]       slot_client [SLOTS];
  bit [TICK_W-1:0]     slot_stamp  [SLOTS];
  bit [NEST_BITS-1:0]  slot_nest   [SLOTS];
  bit [CFG_W-1:0]      hang_limit;
  bit                  armed;

  command_t            cmd_backlog[$];
  result_t             pending_results[$];
  command_t            next_cmd;
  result_t             expected_word;
  int unsigned         send_idle_pct;
  int unsigned         recv_stall_pct;
  int unsigned         mismatches;
  logic [ID_W-1:0]     client_pool [POOL];
  logic [TICK_W-1:0]   tick_now;

  logic [CFG_W-1:0]    phase_timeout [PHASES] = '{32'd50, 32'd1, 32'hFFFF_FFFF, 32'd1000, 32'd0};
  bit                  phase_armed   [PHASES] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
  int unsigned         phase_idle    [PHASES] = '{0, 72, 0, 12, 72};
  int unsigned         phase_stall   [PHASES] = '{0, 0, 72, 12, 0};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int find_client(logic [ID_W-1:0] id);
    for (int i = 0; i < SLOTS; i++)
      if (slot_used[i] && slot_client[i] == id) return i;
    return -1;
  endfunction

  function automatic result_t watchdog_step(logic [CMD_W-1:0] op, logic [ID_W-1:0] id,
                                            logic [TICK_W-1:0] now);
    result_t          r;
    int               hit;
    bit [TICK_W-1:0]  age;
    r = '0;
    r.status = STAT_OK;
    hit = find_client(id);
    case (op)
      CMD_BEAT: begin
        // An unknown client takes the lowest free slot.
        if (hit < 0)
          for (int i = SLOTS - 1; i >= 0; i--)
            if (!slot_used[i]) hit = i;
        if (hit < 0) begin
          r.status = STAT_FULL;
        end else begin
          if (!slot_used[hit]) begin
            slot_used[hit]   = 1'b1;
            slot_client[hit] = id;
            slot_nest[hit]   = '0;
          end
          slot_stamp[hit] = now;
        end
      end
      CMD_REMOVE: begin
        if (hit < 0) r.status = STAT_NOT_FOUND;
        else slot_used[hit] = 1'b0;
      end
      CMD_SUSPEND: begin
        if (hit < 0) r.status = STAT_NOT_FOUND;
        else if (slot_nest[hit] == '1) r.status = STAT_SUSPEND_SAT;
        else slot_nest[hit]++;
      end
      CMD_RESUME: begin
        if (hit < 0) begin
          r.status = STAT_NOT_FOUND;
        end else if (slot_nest[hit] == '0) begin
          r.status = STAT_RESUME_ZERO;
        end else begin
          slot_nest[hit]--;
          if (slot_nest[hit] == '0) slot_stamp[hit] = now;
        end
      end
      CMD_CHECK: begin
        if (armed && hang_limit != '0)
          for (int i = 0; i < SLOTS; i++) begin
            age = now - slot_stamp[i];
            if (!r.hung_found && slot_used[i] && slot_nest[i] == '0 && age > hang_limit) begin
              slot_stamp[i] = now;
              r.hung_found  = 1'b1;
              r.hung_id     = slot_client[i];
            end
          end
      end
      default: ;
    endcase
    hit = find_client(id);
    r.beating = (hit >= 0) && (slot_nest[hit] == '0);
    return r;
  endfunction

  // Sender: the prediction is made from the word as it is accepted.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        pending_results.push_back(watchdog_step(cmd, client_id, now_ticks));
      if (!in_valid || !in_stall) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_cmd  = cmd_backlog.pop_front();
          in_valid  <= 1'b1;
          cmd       <= next_cmd.op;
          client_id <= next_cmd.id;
          now_ticks <= next_cmd.ticks;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: compares each accepted result word with the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result word with none predicted: found %b id %h beating %b status %0d",
                   $time, hung_found, hung_id, beating, status);
          mismatches++;
        end else begin
          expected_word = pending_results.pop_front();
          if (hung_found !== expected_word.hung_found) begin
            $display("%0t: hung_found expected %b got %b", $time, expected_word.hung_found,
                     hung_found);
            mismatches++;
          end
          if (hung_id !== expected_word.hung_id) begin
            $display("%0t: hung_id expected %h got %h", $time, expected_word.hung_id, hung_id);
            mismatches++;
          end
          if (beating !== expected_word.beating) begin
            $display("%0t: beating expected %b got %b", $time, expected_word.beating, beating);
            mismatches++;
          end
          if (status !== expected_word.status) begin
            $display("%0t: status expected %0d got %0d", $time, expected_word.status, status);
            mismatches++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic post(logic [CMD_W-1:0] op, logic [ID_W-1:0] id, logic [TICK_W-1:0] ticks);
    command_t c;
    c.op    = op;
    c.id    = id;
    c.ticks = ticks;
    cmd_backlog.push_back(c);
  endtask

  // Returns at a falling edge once every word is sent and answered, plus a margin.
  task automatic drain();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || in_valid || pending_results.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_HANG_TIMEOUT) hang_limit = value;
    else armed = value[0];
  endtask

  task automatic set_idling(int unsigned idle_pct, int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
  endtask

  // Mostly commands on a small client pool over a running clock, with some raw noise.
  task automatic post_traffic(int unsigned count);
    int unsigned       roll;
    logic [CMD_W-1:0]  op;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 6) begin
        op = CMD_W'($urandom_range(7));
        post(op, $urandom, $urandom);
      end else begin
        roll = $urandom_range(99);
        if (roll < 35) op = CMD_BEAT;
        else if (roll < 45) op = CMD_REMOVE;
        else if (roll < 60) op = CMD_SUSPEND;
        else if (roll < 75) op = CMD_RESUME;
        else op = CMD_CHECK;
        if ($urandom_range(49) == 0) tick_now = $urandom;
        else tick_now += $urandom_range(30);
        post(op, client_pool[$urandom_range(POOL - 1)], tick_now);
      end
    end
  endtask

  initial begin
    logic [ID_W-1:0] id_a;
    logic [ID_W-1:0] id_b;
    logic [ID_W-1:0] id_c;
    logic [ID_W-1:0] nest_id;
    mismatches     = 0;
    hang_limit     = '0;
    armed          = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    tick_now       = 32'h0000_1000;
    id_a           = 32'hA5A5_0001;
    id_b           = 32'h5A5A_0002;
    id_c           = 32'h0000_C0DE;
    nest_id        = 32'h7E57_0BAD;
    client_pool[0] = '0;
    client_pool[1] = '1;
    for (int i = 2; i < POOL; i++) client_pool[i] = $urandom;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings leave checking disarmed.
    post(CMD_BEAT, '0, 32'd10);
    post(CMD_BEAT, '1, 32'd20);
    post(CMD_CHECK, '0, 32'd1000);
    post(CMD_SUSPEND, 32'h1234_5678, 32'd30);
    post(CMD_RESUME, 32'h1234_5678, 32'd30);
    post(CMD_REMOVE, 32'h1234_5678, 32'd30);
    post(3'd5, '0, 32'd40);
    post(3'd6, '0, 32'd40);
    post(3'd7, '0, 32'd40);
    post(CMD_RESUME, '0, 32'd50);
    post(CMD_SUSPEND, '0, 32'd60);
    post(CMD_CHECK, '0, '1);
    post(CMD_RESUME, '0, 32'd500);
    post(CMD_REMOVE, '1, 32'd510);
    drain();

    write_reg(REG_HANG_TIMEOUT, 32'd10);
    write_reg(REG_CHECK_ENABLE, 32'd1);
    post(CMD_REMOVE, '0, 32'd90);
    post(CMD_BEAT, id_a, 32'd100);
    post(CMD_BEAT, id_b, 32'd100);
    post(CMD_CHECK, '0, 32'd105);
    post(CMD_CHECK, id_a, 32'd111);
    post(CMD_CHECK, id_b, 32'd111);
    post(CMD_CHECK, '0, 32'd111);
    post(CMD_SUSPEND, id_a, 32'd150);
    post(CMD_CHECK, id_a, 32'd200);
    // The third client's age wraps through zero.
    post(CMD_BEAT, id_c, 32'hFFFF_FFF0);
    post(CMD_CHECK, id_c, 32'd5);
    post(CMD_CHECK, id_c, 32'd5);
    drain();

    // Nest one client to saturation and back, ending with a resume at zero.
    set_idling(12, 12);
    post(CMD_BEAT, nest_id, 32'd300);
    repeat (257) post(CMD_SUSPEND, nest_id, 32'd310);
    post(CMD_CHECK, nest_id, 32'd9000);
    repeat (256) post(CMD_RESUME, nest_id, 32'd320);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      write_reg(REG_HANG_TIMEOUT, phase_timeout[p]);
      write_reg(REG_CHECK_ENABLE, CFG_W'(phase_armed[p]));
      @(negedge clk);
      set_idling(phase_idle[p], phase_stall[p]);
      post_traffic(26);
      // Hold the sender off until the block has answered everything.
      drain();
      post_traffic(26);
      drain();
    end

    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
